>>> rtl/core/cel_pkg.sv
// Shared constants for the compacting entry list: request kinds, status codes,
// default sizes and port widths. No dependencies.
`timescale 1ns / 1ps

package cel_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int ENTRY_WIDTH_DEF = 32;

  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 7;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 40;

  typedef enum logic [KIND_W-1:0] {
    REQ_APPEND     = 2'd0,
    REQ_REMOVE_AT  = 2'd1,
    REQ_REMOVE_VAL = 2'd2,
    REQ_GET        = 2'd3
  } req_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

>>> rtl/core/compacting_entry_list.sv
// Compacting entry list: ordered word list in a single-port-write, registered-read
// memory, driven by a small sequencer. Depends on cel_pkg.
// An append or a rejected request goes straight to the result; get reads one
// entry; remove at index shifts the entries above the position down; remove by
// value searches from the last entry down, then shifts the same tail.
// One item in flight; the one memory read port is walked one entry a cycle
// during search and shift. Sync active-low reset clears count and control;
// entry memory is not cleared.
`timescale 1ns / 1ps

module compacting_entry_list #(
  parameter int DEPTH       = cel_pkg::DEPTH_DEF,
  parameter int ENTRY_WIDTH = cel_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [cel_pkg::IN_DW-1:0]   in_tdata,   // [5:0] position, [37:6] item_value
  input  logic [cel_pkg::KIND_W-1:0]  in_tuser,   // [1:0] req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [cel_pkg::OUT_DW-1:0]  out_tdata,  // [31:0] read_value, [38:32] entry_count
  output logic [cel_pkg::STAT_W-1:0]  out_tuser   // [1:0] status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE        = 8'b0000_0001,
    S_SCAN_PRIME  = 8'b0000_0010,
    S_SCAN_RUN    = 8'b0000_0100,
    S_SHIFT_PRIME = 8'b0000_1000,
    S_SHIFT_RUN   = 8'b0001_0000,
    S_GET_RD      = 8'b0010_0000,
    S_GET_DATA    = 8'b0100_0000,
    S_DONE        = 8'b1000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;      // shift dest / scan compare index
  logic [ENTRY_WIDTH-1:0]       word_r, word_nxt;
  logic [cel_pkg::STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [cel_pkg::VAL_W-1:0]    res_value_r, res_value_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [cel_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [cel_pkg::VAL_W-1:0]    out_value_r, out_value_nxt;
  logic [cel_pkg::CNT_W-1:0]    out_count_r, out_count_nxt;

  logic [ENTRY_WIDTH-1:0]       mem [DEPTH];
  logic [ENTRY_WIDTH-1:0]       rdata_r;
  logic                         we;
  logic [AW-1:0]                wa, ra;
  logic [ENTRY_WIDTH-1:0]       wd;

  logic [cel_pkg::POS_W-1:0]    in_pos;
  logic [cel_pkg::VAL_W-1:0]    in_val;
  logic [63:0]                  in_val_ext, rdata_ext;
  logic [31:0]                  count_ext;
  logic                         accept, pos_ok, full, hit;
  logic [CW-1:0]                idx_inc;

  assign in_pos     = in_tdata[cel_pkg::POS_W-1:0];
  assign in_val     = in_tdata[cel_pkg::POS_W +: cel_pkg::VAL_W];
  assign in_val_ext = {32'd0, in_val};
  assign rdata_ext  = 64'(rdata_r);
  assign count_ext  = 32'(count_r);
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign pos_ok     = 32'(in_pos) < count_ext;
  assign full       = count_ext >= 32'(DEPTH);
  assign hit        = (rdata_r == word_r);
  assign idx_inc    = idx_r + CW'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    word_nxt       = word_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    we             = 1'b0;
    wa             = count_r[AW-1:0];
    wd             = in_val_ext[ENTRY_WIDTH-1:0];
    ra             = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          word_nxt       = in_val_ext[ENTRY_WIDTH-1:0];
          idx_nxt        = CW'(in_pos);
          res_status_nxt = cel_pkg::ST_OK;
          res_value_nxt  = '0;
          state_nxt      = S_DONE;
          case (in_tuser)
            cel_pkg::REQ_APPEND: begin
              if (full) begin
                res_status_nxt = cel_pkg::ST_FULL;
              end else begin
                we        = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            cel_pkg::REQ_REMOVE_AT: begin
              if (!pos_ok) begin
                res_status_nxt = cel_pkg::ST_BAD_INDEX;
              end else begin
                count_nxt = count_r - CW'(1);
                state_nxt = S_SHIFT_PRIME;
              end
            end
            cel_pkg::REQ_REMOVE_VAL: begin
              if (count_r == '0) begin
                res_status_nxt = cel_pkg::ST_NOT_FOUND;
              end else begin
                idx_nxt   = count_r - CW'(1);
                state_nxt = S_SCAN_PRIME;
              end
            end
            default: begin
              if (!pos_ok) begin
                res_status_nxt = cel_pkg::ST_BAD_INDEX;
              end else begin
                state_nxt = S_GET_RD;
              end
            end
          endcase
        end
      end
      S_SCAN_PRIME: begin
        state_nxt = S_SCAN_RUN;
      end
      S_SCAN_RUN: begin
        // rdata holds entry idx; search runs downward so the first hit is the last match
        if (hit) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_SHIFT_PRIME;
        end else if (idx_r == '0) begin
          res_status_nxt = cel_pkg::ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          ra      = AW'(idx_r - CW'(1));
          idx_nxt = idx_r - CW'(1);
        end
      end
      S_SHIFT_PRIME: begin
        // count already holds the new length; dest idx runs up to count-1
        ra = AW'(idx_inc);
        if (idx_r < count_r) begin
          state_nxt = S_SHIFT_RUN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_RUN: begin
        we      = 1'b1;
        wa      = idx_r[AW-1:0];
        wd      = rdata_r;
        idx_nxt = idx_inc;
        ra      = AW'(idx_inc + CW'(1));
        if (idx_inc >= count_r) begin
          state_nxt = S_DONE;
        end
      end
      S_GET_RD: begin
        state_nxt = S_GET_DATA;
      end
      S_GET_DATA: begin
        res_value_nxt = rdata_ext[cel_pkg::VAL_W-1:0];
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_count_nxt  = count_ext[cel_pkg::CNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    word_r       <= word_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_count_r, out_value_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DEPTH))
    else $error("entry count above capacity");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_RUN) |-> (idx_r < count_r))
    else $error("shift destination past end of list");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == cel_pkg::REQ_APPEND && !full)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("append did not grow the list");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_tready) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished item not moved to output");

endmodule
